// ===== src/lcd_page_format_converter_core_defines.svh =====
// Assertion macros shared by the checker of the LCD page format converter.
`ifndef LCD_PAGE_FORMAT_CONVERTER_CORE_DEFINES_SVH
`define LCD_PAGE_FORMAT_CONVERTER_CORE_DEFINES_SVH

// Implication that must hold in the same cycle.
`define LPFC_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("lcdpfc: same-cycle check failed");

// Implication whose consequent starts in the next cycle.
`define LPFC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("lcdpfc: next-cycle check failed");

`endif

// ===== src/lcdpfc_pkg.sv =====
// Shared constants, types and command structs of the LCD page format converter.
package lcdpfc_pkg;

  localparam int WIDTH_PIXELS  = 160;
  localparam int PAGES         = 6;
  localparam int HEADER_BYTES  = 32;

  localparam int ADDR_W        = 10;
  localparam int DATA_W        = 8;
  localparam int LANES         = 8;
  localparam logic [DATA_W-1:0] REPORT_ID_RESET = 8'h03;

  localparam int BYTES_PER_ROW = (WIDTH_PIXELS + 7) / 8;
  localparam int ROWS          = PAGES * 8;
  localparam int STORE_BYTES   = BYTES_PER_ROW * ROWS;
  localparam int REPORT_BYTES  = HEADER_BYTES + PAGES * WIDTH_PIXELS;
  localparam int BANK_DEPTH    = BYTES_PER_ROW * PAGES;
  localparam int BANK_AW       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int ROW_W         = $clog2(ROWS);
  localparam int COL_W         = $clog2(WIDTH_PIXELS);

  // Constant division by reciprocal: q = (x * RECIP) >> DIV_SHIFT.
  localparam int DIV_SHIFT     = 24;
  localparam int RECIP_W       = DIV_SHIFT + 1;
  localparam int PROD_W        = ADDR_W + RECIP_W;
  localparam int MUL_W         = ADDR_W + 1;
  localparam int RECIP_ROW     = (1 << DIV_SHIFT) / BYTES_PER_ROW + 1;
  localparam int RECIP_COL     = (1 << DIV_SHIFT) / WIDTH_PIXELS + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUOT,
    ST_REM,
    ST_ACCESS,
    ST_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic clear;
    logic capture;
    logic quot_en;
    logic rem_en;
    logic access_en;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/lcd_page_format_converter_core.sv =====
// Top level of the LCD page format converter: row-major bitmap in, page report out.
// A request is captured when accepted and passes the quotient, remainder, bank access
// and result states; the result state loads the output register once it is free.
// The sequencer handles one request at a time, taking the next only after that load.
// Reset: report_id returns to 3 and a clearing pass zeroes the frame store, one
// bank row a cycle over all 120 addresses of each bank, while input is stalled; configuration stays open.
module lcd_page_format_converter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [lcdpfc_pkg::ADDR_W-1:0]       address_i,
  input  logic [lcdpfc_pkg::DATA_W-1:0]       write_byte_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lcdpfc_pkg::DATA_W-1:0]       report_byte_o,
  output logic                                bad_address_o,
  // Configuration channel: the report id register.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lcdpfc_pkg::DATA_W-1:0]       cfg_report_id_i
);

  // The frame store is split into eight row banks, one per row of a page, so a
  // page column is gathered with a single access to all banks. A write request
  // lands in one bank only. Address splitting (row and byte column on writes,
  // page and pixel column on reads) uses reciprocal multiplication, one
  // multiply per cycle with the quotient registered before the remainder.
  lcdpfc_pkg::dp_cmd_t    cmd;
  lcdpfc_pkg::dp_status_t status;

  // The single register is always writable; it is only sampled for header reads.
  assign cfg_ready_o = 1'b1;

  // The controller sequences one request at a time; a finished result waits in
  // the output register, so the next request is taken while it is pending.
  lcdpfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lcdpfc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .func_i          (func_i),
    .address_i       (address_i),
    .write_byte_i    (write_byte_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_report_id_i (cfg_report_id_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .report_byte_o   (report_byte_o),
    .bad_address_o   (bad_address_o)
  );

endmodule

// ===== src/lcdpfc_ram.sv =====
// Generic single-port RAM with registered read data.
module lcdpfc_ram #(
  parameter int DataW = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lcdpfc_ctrl.sv =====
// Sequencing state machine of the LCD page format converter.
module lcdpfc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  lcdpfc_pkg::dp_status_t status_i,
  output lcdpfc_pkg::dp_cmd_t    cmd_o
);

  lcdpfc_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcdpfc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      lcdpfc_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = lcdpfc_pkg::ST_IDLE;
        end
      end
      lcdpfc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = lcdpfc_pkg::ST_QUOT;
        end
      end
      lcdpfc_pkg::ST_QUOT: begin
        cmd_o.quot_en = 1'b1;
        state_d       = lcdpfc_pkg::ST_REM;
      end
      lcdpfc_pkg::ST_REM: begin
        cmd_o.rem_en = 1'b1;
        state_d      = lcdpfc_pkg::ST_ACCESS;
      end
      lcdpfc_pkg::ST_ACCESS: begin
        cmd_o.access_en = 1'b1;
        state_d         = lcdpfc_pkg::ST_RESULT;
      end
      lcdpfc_pkg::ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = lcdpfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lcdpfc_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/lcdpfc_datapath.sv =====
// Address decode, row banks, column gather and output register.
module lcdpfc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lcdpfc_pkg::dp_cmd_t                 cmd_i,
  output lcdpfc_pkg::dp_status_t              status_o,
  input  logic                                func_i,
  input  logic [lcdpfc_pkg::ADDR_W-1:0]       address_i,
  input  logic [lcdpfc_pkg::DATA_W-1:0]       write_byte_i,
  input  logic                                cfg_valid_i,
  input  logic [lcdpfc_pkg::DATA_W-1:0]       cfg_report_id_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lcdpfc_pkg::DATA_W-1:0]       report_byte_o,
  output logic                                bad_address_o
);

  localparam int AW = lcdpfc_pkg::BANK_AW;
  localparam int DW = lcdpfc_pkg::DATA_W;

  // Item registers.
  logic                           func_q, bad_q, hdr_q, id0_q;
  logic [lcdpfc_pkg::ADDR_W-1:0]  x_q;
  logic [DW-1:0]                  wbyte_q;
  logic [lcdpfc_pkg::ROW_W-1:0]   quot_q;
  logic [lcdpfc_pkg::COL_W-1:0]   rem_q;
  logic [AW-1:0]                  page_base_q;
  logic [2:0]                     bank_sel_q;
  logic [DW-1:0]                  report_id_q;
  logic [AW-1:0]                  clr_cnt_q;
  logic                           out_valid_q;
  logic [DW-1:0]                  report_byte_q;
  logic                           bad_out_q;

  logic [lcdpfc_pkg::ADDR_W-1:0]  x_d;
  logic                           bad_d;
  logic [lcdpfc_pkg::RECIP_W-1:0] recip;
  logic [lcdpfc_pkg::PROD_W-1:0]  prod;
  logic [lcdpfc_pkg::MUL_W-1:0]   divisor, quot_mul, rem_full;
  logic [lcdpfc_pkg::ROW_W-1:0]   page;
  logic [lcdpfc_pkg::COL_W-1:0]   byte_col;
  logic [AW-1:0]                  bank_addr;
  logic [AW-1:0]                  ram_addr;
  logic [DW-1:0]                  ram_wdata;
  logic [lcdpfc_pkg::LANES-1:0]   ram_we;
  logic                           ram_re;
  logic [DW-1:0]                  rdata [lcdpfc_pkg::LANES];
  logic [DW-1:0]                  gathered;
  logic [DW-1:0]                  result;

  // Capture decode: reads index past the header, writes index the bitmap.
  always_comb begin
    x_d   = func_i ? address_i - lcdpfc_pkg::ADDR_W'(lcdpfc_pkg::HEADER_BYTES) : address_i;
    bad_d = func_i ? (32'(address_i) >= lcdpfc_pkg::REPORT_BYTES)
                   : (32'(address_i) >= lcdpfc_pkg::STORE_BYTES);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_i;
      x_q     <= x_d;
      wbyte_q <= write_byte_i;
      bad_q   <= bad_d;
      hdr_q   <= 32'(address_i) < lcdpfc_pkg::HEADER_BYTES;
      id0_q   <= address_i == '0;
    end
    if (cmd_i.quot_en) begin
      quot_q <= prod[lcdpfc_pkg::DIV_SHIFT +: lcdpfc_pkg::ROW_W];
    end
    if (cmd_i.rem_en) begin
      rem_q       <= rem_full[lcdpfc_pkg::COL_W-1:0];
      page_base_q <= AW'(page * lcdpfc_pkg::BYTES_PER_ROW);
      bank_sel_q  <= quot_q[2:0];
    end
  end

  // Quotient: row on writes, page on reads.
  always_comb begin
    recip = func_q ? lcdpfc_pkg::RECIP_W'(lcdpfc_pkg::RECIP_COL)
                   : lcdpfc_pkg::RECIP_W'(lcdpfc_pkg::RECIP_ROW);
    prod  = lcdpfc_pkg::PROD_W'(x_q) * lcdpfc_pkg::PROD_W'(recip);
  end

  // Remainder and page base: byte column on writes, pixel column on reads.
  always_comb begin
    divisor  = func_q ? lcdpfc_pkg::MUL_W'(lcdpfc_pkg::WIDTH_PIXELS)
                      : lcdpfc_pkg::MUL_W'(lcdpfc_pkg::BYTES_PER_ROW);
    quot_mul = lcdpfc_pkg::MUL_W'(quot_q) * divisor;
    rem_full = lcdpfc_pkg::MUL_W'(x_q) - quot_mul;
    page     = func_q ? quot_q : (quot_q >> 3);
  end

  always_comb begin
    byte_col  = func_q ? (rem_q >> 3) : rem_q;
    bank_addr = page_base_q + AW'(byte_col);
    ram_addr  = cmd_i.clear ? clr_cnt_q : bank_addr;
    ram_wdata = cmd_i.clear ? '0 : wbyte_q;
    ram_re    = cmd_i.access_en & func_q & ~bad_q & ~hdr_q;
  end

  for (genvar b = 0; b < lcdpfc_pkg::LANES; b++) begin : g_bank
    assign ram_we[b] = cmd_i.clear |
                       (cmd_i.access_en & ~func_q & ~bad_q & (bank_sel_q == 3'(b)));

    lcdpfc_ram #(
      .DataW (DW),
      .Depth (lcdpfc_pkg::BANK_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (ram_we[b]),
      .re_i    (ram_re),
      .addr_i  (ram_addr),
      .wdata_i (ram_wdata),
      .rdata_o (rdata[b])
    );
  end

  // Bank r holds row r of every page; the pixel sits at bit 7 - col%8.
  always_comb begin
    for (int r = 0; r < lcdpfc_pkg::LANES; r++) begin
      gathered[r] = rdata[r][~rem_q[2:0]];
    end
    if (!func_q || bad_q) begin
      result = '0;
    end else if (hdr_q) begin
      result = id0_q ? report_id_q : '0;
    end else begin
      result = gathered;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_id_q <= lcdpfc_pkg::REPORT_ID_RESET;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        report_id_q <= cfg_report_id_i;
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      report_byte_q <= result;
      bad_out_q     <= bad_q;
    end
  end

  assign status_o.clear_last = clr_cnt_q == AW'(lcdpfc_pkg::BANK_DEPTH - 1);
  assign status_o.out_free   = ~out_valid_q | ~out_stall_i;
  assign out_valid_o         = out_valid_q;
  assign report_byte_o       = report_byte_q;
  assign bad_address_o       = bad_out_q;

endmodule

// ===== src/lcdpfc_checker.sv =====
// Port-level checker of the LCD page format converter and its bind.
`include "lcd_page_format_converter_core_defines.svh"

module lcdpfc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [lcdpfc_pkg::DATA_W-1:0] report_byte_o,
  input logic                          bad_address_o
);

  // A stalled result keeps its value.
  `LPFC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(report_byte_o) && $stable(bad_address_o))

  // An accepted request keeps the input stalled while the sequencer works on it.
  `LPFC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o ##1 in_stall_o ##1 in_stall_o)

  // A flagged address never carries data.
  `LPFC_ASSERT_NOW(a_bad_is_zero, out_valid_o && bad_address_o, report_byte_o == '0)

endmodule

bind lcd_page_format_converter_core lcdpfc_checker u_lcdpfc_checker (.*);
